/* rtl/utf16_to_utf8_encoder_macros.svh */
// Assertion helpers for the top-level encoder, which checks its own logic.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define U2U8_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define U2U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/u2u8_pkg.sv */
package u2u8_pkg;

  // Upper six bits of a high and a low surrogate code unit.
  localparam logic [5:0] HIGH_PREFIX = 6'b110110;
  localparam logic [5:0] LOW_PREFIX  = 6'b110111;

  // What the main part of a job emits, after an optional flush of a held unit.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_PAIR
  } kind_t;

  typedef struct packed {
    logic        flush;
    logic [9:0]  held;
    kind_t       kind;
    logic [15:0] unit;
  } job_t;

  function automatic logic [2:0] main_count(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_NONE:  n = 3'd0;
      KIND_ONE:   n = 3'd1;
      KIND_TWO:   n = 3'd2;
      KIND_THREE: n = 3'd3;
      KIND_PAIR:  n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/utf16_to_utf8_encoder.sv */
// A unit's job passes through the two-entry queue and the back end's job register before
// its first byte reaches the output register. The output carries one byte per cycle while
// byte_ready is high and jobs are waiting; an item emits 1 to 6 bytes, serialized by the back end.
// A high surrogate emits nothing until the next unit: with a low one it forms a pair, else it is flushed.
// Reset (rst, synchronous, active high) empties the queue and the output register
// and drops any held surrogate.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] code_unit,
  input  logic        unit_valid,
  output logic        unit_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        byte_valid,
  input  logic        byte_ready
);

`include "utf16_to_utf8_encoder_macros.svh"

  // The front end classifies each unit against the held high surrogate and
  // turns it into a job: an optional flush of the held unit plus the main
  // encoding. Jobs wait in a two-entry queue so that the front end keeps
  // taking units while the back end is still sending bytes.
  u2u8_pkg::job_t front_job;
  u2u8_pkg::job_t queue_job;
  logic           front_push;
  logic           queue_ready;
  logic           queue_valid;
  logic           back_pop;
  logic           held_valid;

  u2u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .code_unit   (code_unit),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .queue_ready (queue_ready),
    .push        (front_push),
    .job         (front_job),
    .held_valid  (held_valid)
  );

  u2u8_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_job   (front_job),
    .push_ready (queue_ready),
    .pop        (back_pop),
    .pop_valid  (queue_valid),
    .pop_job    (queue_job)
  );

  // The back end walks each job one byte per cycle, while the consumer keeps up, into an
  // output register, which parts it from the consumer so a stall there does not stop the queue
  // from filling.
  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (queue_valid),
    .job_in     (queue_job),
    .pop        (back_pop),
    .out_byte   (out_byte),
    .last       (last),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready)
  );

  // A high surrogate transfer always leaves a unit held.
  `U2U8_ASSERT_NEXT(a_high_held, clk, rst,
    unit_valid && unit_ready && code_unit[15:10] == u2u8_pkg::HIGH_PREFIX, held_valid)
  // A low surrogate transfer always releases the held unit.
  `U2U8_ASSERT_NEXT(a_low_clears, clk, rst,
    unit_valid && unit_ready && code_unit[15:10] == u2u8_pkg::LOW_PREFIX, !held_valid)
  // Within one item the bytes follow each other without a gap.
  `U2U8_ASSERT_NEXT(a_no_gap, clk, rst, byte_valid && byte_ready && !last, byte_valid)

endmodule

/* rtl/u2u8_front.sv */
module u2u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       code_unit,
  input  logic              unit_valid,
  output logic              unit_ready,
  input  logic              queue_ready,
  output logic              push,
  output u2u8_pkg::job_t    job,
  output logic              held_valid
);

  logic [9:0] held_high;
  logic       accept;
  logic       is_high;
  logic       is_low;

  assign unit_ready = queue_ready;
  assign accept     = unit_valid && queue_ready;
  assign is_high    = code_unit[15:10] == u2u8_pkg::HIGH_PREFIX;
  assign is_low     = code_unit[15:10] == u2u8_pkg::LOW_PREFIX;

  always_comb begin
    job.flush = held_valid && !is_low;
    job.held  = held_high;
    job.unit  = code_unit;
    priority if (held_valid && is_low) begin
      job.kind = u2u8_pkg::KIND_PAIR;
    end else if (code_unit[15:7] == 9'd0) begin
      job.kind = u2u8_pkg::KIND_ONE;
    end else if (code_unit[15:11] == 5'd0) begin
      job.kind = u2u8_pkg::KIND_TWO;
    end else if (is_high) begin
      job.kind = u2u8_pkg::KIND_NONE;
    end else begin
      job.kind = u2u8_pkg::KIND_THREE;
    end
  end

  // A lone high surrogate with nothing held produces no bytes and no job.
  assign push = accept && (job.flush || job.kind != u2u8_pkg::KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= is_high;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_high <= code_unit[9:0];
    end
  end

endmodule

/* rtl/u2u8_fifo.sv */
module u2u8_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u2u8_pkg::job_t    push_job,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output u2u8_pkg::job_t    pop_job
);

  u2u8_pkg::job_t slot0;
  u2u8_pkg::job_t slot1;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_job    = rd_ptr ? slot1 : slot0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_ptr) begin
      slot0 <= push_job;
    end
    if (do_push && wr_ptr) begin
      slot1 <= push_job;
    end
  end

endmodule

/* rtl/u2u8_back.sv */
module u2u8_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  u2u8_pkg::job_t    job_in,
  output logic              pop,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              byte_valid,
  input  logic              byte_ready
);

  // Byte k of the three-byte form of a 16-bit unit.
  function automatic logic [7:0] three_byte(input logic [15:0] u, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = {4'hE, u[15:12]};
      2'd1:    b = {2'b10, u[11:6]};
      default: b = {2'b10, u[5:0]};
    endcase
    return b;
  endfunction

  u2u8_pkg::job_t cur;
  logic           cur_valid;
  logic [2:0]     idx;
  logic [2:0]     total;
  logic           load;
  logic           at_end;
  logic           in_flush;
  logic [2:0]     main_idx;
  logic [20:0]    cp;
  logic [7:0]     main_byte;
  logic [7:0]     byte_next;

  assign total    = (cur.flush ? 3'd3 : 3'd0) + u2u8_pkg::main_count(cur.kind);
  assign load     = cur_valid && (!byte_valid || byte_ready);
  assign at_end   = idx == total - 3'd1;
  assign pop      = !cur_valid || (load && at_end);
  assign in_flush = cur.flush && (idx < 3'd3);
  assign main_idx = cur.flush ? idx - 3'd3 : idx;
  assign cp       = {1'b0, cur.held, cur.unit[9:0]} + 21'h10000;

  always_comb begin
    unique case (cur.kind)
      u2u8_pkg::KIND_ONE: begin
        main_byte = cur.unit[7:0];
      end
      u2u8_pkg::KIND_TWO: begin
        main_byte = (main_idx == 3'd0) ? {3'b110, cur.unit[10:6]} : {2'b10, cur.unit[5:0]};
      end
      u2u8_pkg::KIND_THREE: begin
        main_byte = three_byte(cur.unit, main_idx[1:0]);
      end
      u2u8_pkg::KIND_PAIR: begin
        unique case (main_idx[1:0])
          2'd0:    main_byte = {5'b11110, cp[20:18]};
          2'd1:    main_byte = {2'b10, cp[17:12]};
          2'd2:    main_byte = {2'b10, cp[11:6]};
          default: main_byte = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        main_byte = 8'd0;
      end
    endcase
    byte_next = in_flush ? three_byte({u2u8_pkg::HIGH_PREFIX, cur.held}, idx[1:0])
                         : main_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      byte_valid <= 1'b0;
      idx        <= 3'd0;
    end else begin
      if (pop) begin
        cur_valid <= job_valid;
        idx       <= 3'd0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
      if (load) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && job_valid) begin
      cur <= job_in;
    end
    if (load) begin
      out_byte <= byte_next;
      last     <= at_end;
    end
  end

endmodule
